// File: src/sspd_pkg.sv
// Package for the seven-segment port display driver.
// Holds sizes, command bytes, transfer kinds and controller/datapath structs.
// No dependencies.
package sspd_pkg;

    localparam int PORTS          = 20;
    localparam int PORTS_PER_CHIP = 5;
    localparam int CHIPS          = (PORTS + PORTS_PER_CHIP - 1) / PORTS_PER_CHIP;
    localparam int SLOTS          = CHIPS * PORTS_PER_CHIP;
    localparam int SLOT_W         = $clog2(SLOTS);
    localparam int CHIP_W         = (CHIPS > 1) ? $clog2(CHIPS) : 1;

    // per chip: mode, address, one data group per port, control
    localparam int STEPS_PER_CHIP = PORTS_PER_CHIP + 3;
    localparam int STEP_W         = $clog2(STEPS_PER_CHIP);

    localparam int PORT_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int SEG_W     = 8;
    localparam int CHIPSEL_W = 3;
    localparam int BCD_W     = 12;   // three decimal digits

    // double dabble: four value bits per cycle
    localparam int CONV_BITS   = 4;
    localparam int CONV_CYCLES = VALUE_W / CONV_BITS;
    localparam int CONV_CNT_W  = (CONV_CYCLES > 1) ? $clog2(CONV_CYCLES) : 1;

    localparam logic [SEG_W-1:0]   CMD_MODE   = 8'h40;
    localparam logic [SEG_W-1:0]   CMD_ADDR   = 8'hC0;
    localparam logic [SEG_W-1:0]   CMD_CTRL   = 8'h8F;
    localparam logic [SEG_W-1:0]   DASH_CODE  = 8'h40;
    localparam logic [VALUE_W-1:0] DASH_VALUE = 16'hFFFF;
    localparam logic [SEG_W-1:0]   SEG_ZERO   = 8'h3F;

    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_THREE = 2'd3;

    localparam logic [STEP_W-1:0] STEP_MODE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_ADDR  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_DATA0 = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_CTRL  = STEP_W'(STEPS_PER_CHIP - 1);

    typedef enum logic [1:0] {
        KIND_MODE = 2'd0,
        KIND_ADDR = 2'd1,
        KIND_DATA = 2'd2,
        KIND_CTRL = 2'd3
    } t_kind;

    typedef struct packed {
        logic              capture;    // latch port and value, start conversion
        logic              conv_step;  // one double-dabble step
        logic              commit;     // write segment codes into the store
        logic              load;       // load output register with next transfer
        logic [CHIP_W-1:0] chip;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic port_ok;
    } t_status;

endpackage

// File: src/sspd_if.sv
// Handshake channel interfaces for the display driver: input item and output transfer.
// Depends on sspd_pkg.
interface sspd_in_if;
    logic                         valid;
    logic                         ready;
    logic [sspd_pkg::PORT_W-1:0]  port;
    logic [sspd_pkg::VALUE_W-1:0] value;

    modport source (output valid, output port, output value, input ready);
    modport sink   (input valid, input port, input value, output ready);
endinterface

interface sspd_out_if;
    logic                           valid;
    logic                           ready;
    logic [sspd_pkg::CHIPSEL_W-1:0] chip;
    logic [1:0]                     kind;
    logic [sspd_pkg::SEG_W-1:0]     byte_a;
    logic [sspd_pkg::SEG_W-1:0]     byte_b;
    logic [sspd_pkg::SEG_W-1:0]     byte_c;
    logic [1:0]                     byte_count;
    logic                           strobe_end;
    logic                           last;

    modport source (output valid, output chip, output kind, output byte_a, output byte_b,
                    output byte_c, output byte_count, output strobe_end, output last,
                    input ready);
    modport sink   (input valid, input chip, input kind, input byte_a, input byte_b,
                    input byte_c, input byte_count, input strobe_end, input last,
                    output ready);
endinterface

// File: src/sspd_ctrl.sv
// Controller FSM: input handshake, conversion sequencing, refresh transfer counter.
// Depends on sspd_pkg.
module sspd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  sspd_pkg::t_status  i_status,
    output sspd_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_WRITE,
        S_EMIT
    } t_state;

    t_state                             r_state, n_state;
    logic [sspd_pkg::CONV_CNT_W-1:0]    r_conv_cnt, n_conv_cnt;
    logic [sspd_pkg::CHIP_W-1:0]        r_chip, n_chip;
    logic [sspd_pkg::STEP_W-1:0]        r_step, n_step;
    logic                               r_out_valid, n_out_valid;
    logic                               load;
    logic                               last_xfer;

    assign load      = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign last_xfer = (r_chip == sspd_pkg::CHIP_W'(sspd_pkg::CHIPS - 1))
                    && (r_step == sspd_pkg::STEP_CTRL);

    always_comb begin
        n_state     = r_state;
        n_conv_cnt  = r_conv_cnt;
        n_chip      = r_chip;
        n_step      = r_step;
        n_out_valid = r_out_valid;

        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.port_ok) begin
                    n_state    = S_CONV;
                    n_conv_cnt = '0;
                end
            end
            S_CONV: begin
                n_conv_cnt = r_conv_cnt + 1'b1;
                if (r_conv_cnt == sspd_pkg::CONV_CNT_W'(sspd_pkg::CONV_CYCLES - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_EMIT;
                n_chip  = '0;
                n_step  = sspd_pkg::STEP_MODE;
            end
            S_EMIT: begin
                if (load) begin
                    if (last_xfer) begin
                        n_state = S_IDLE;
                    end else if (r_step == sspd_pkg::STEP_CTRL) begin
                        n_step = sspd_pkg::STEP_MODE;
                        n_chip = r_chip + 1'b1;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_conv_cnt  <= '0;
            r_chip      <= '0;
            r_step      <= sspd_pkg::STEP_MODE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_conv_cnt  <= n_conv_cnt;
            r_chip      <= n_chip;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cmd.capture     = (r_state == S_IDLE) && i_in_valid && i_status.port_ok;
    assign o_cmd.conv_step   = (r_state == S_CONV);
    assign o_cmd.commit      = (r_state == S_WRITE);
    assign o_cmd.load        = load;
    assign o_cmd.chip        = r_chip;
    assign o_cmd.step        = r_step;

endmodule

// File: src/sspd_dpath.sv
// Datapath: BCD converter, per-port segment code store, transfer output register.
// Depends on sspd_pkg.
module sspd_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sspd_pkg::PORT_W-1:0]      i_port,
    input  logic [sspd_pkg::VALUE_W-1:0]     i_value,
    input  sspd_pkg::t_cmd                   i_cmd,
    output sspd_pkg::t_status                o_status,
    output logic [sspd_pkg::CHIPSEL_W-1:0]   o_chip,
    output logic [1:0]                       o_kind,
    output logic [sspd_pkg::SEG_W-1:0]       o_byte_a,
    output logic [sspd_pkg::SEG_W-1:0]       o_byte_b,
    output logic [sspd_pkg::SEG_W-1:0]       o_byte_c,
    output logic [1:0]                       o_byte_count,
    output logic                             o_strobe_end,
    output logic                             o_last
);

    localparam int CODES_W = 3 * sspd_pkg::SEG_W;
    localparam logic [CODES_W-1:0] ZERO_CODES = {3{sspd_pkg::SEG_ZERO}};
    localparam logic [CODES_W-1:0] DASH_CODES = {3{sspd_pkg::DASH_CODE}};

    function automatic logic [sspd_pkg::SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [sspd_pkg::SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = '0;
        endcase
        return code;
    endfunction

    logic [sspd_pkg::VALUE_W-1:0] r_bin, n_bin;
    logic [sspd_pkg::BCD_W-1:0]   r_bcd, n_bcd;
    logic                         r_dash;
    logic [sspd_pkg::SLOT_W-1:0]  r_slot;
    logic [CODES_W-1:0]           r_codes [sspd_pkg::SLOTS];
    logic [CODES_W-1:0]           new_codes;
    logic [sspd_pkg::STEP_W-1:0]  grp;
    logic [sspd_pkg::SLOT_W-1:0]  rd_slot;
    logic [CODES_W-1:0]           rd_codes;

    assign o_status.port_ok = (i_port != '0)
                           && (i_port <= sspd_pkg::PORT_W'(sspd_pkg::PORTS));

    // Four shift-and-add-3 steps; thousands carry drops off the top (mod 1000).
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        for (int k = 0; k < sspd_pkg::CONV_BITS; k++) begin
            for (int d = 0; d < 3; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[sspd_pkg::BCD_W-2:0], n_bin[sspd_pkg::VALUE_W-1]};
            n_bin = {n_bin[sspd_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bin  <= i_value;
            r_bcd  <= '0;
            r_dash <= (i_value == sspd_pkg::DASH_VALUE);
            r_slot <= sspd_pkg::SLOT_W'(i_port - 1'b1);
        end else if (i_cmd.conv_step) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign new_codes = r_dash ? DASH_CODES
                     : {seg_of(r_bcd[11:8]), seg_of(r_bcd[7:4]), seg_of(r_bcd[3:0])};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < sspd_pkg::SLOTS; s++) begin
                r_codes[s] <= ZERO_CODES;
            end
        end else if (i_cmd.commit) begin
            r_codes[r_slot] <= new_codes;
        end
    end

    assign grp     = i_cmd.step - sspd_pkg::STEP_DATA0;
    assign rd_slot = sspd_pkg::SLOT_W'(i_cmd.chip * sspd_pkg::PORTS_PER_CHIP)
                   + sspd_pkg::SLOT_W'(grp);
    assign rd_codes = (32'(rd_slot) < sspd_pkg::SLOTS) ? r_codes[rd_slot] : ZERO_CODES;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_chip <= sspd_pkg::CHIPSEL_W'(i_cmd.chip) + 1'b1;
            o_last <= 1'b0;
            case (i_cmd.step)
                sspd_pkg::STEP_MODE: begin
                    o_kind       <= sspd_pkg::KIND_MODE;
                    o_byte_a     <= sspd_pkg::CMD_MODE;
                    o_byte_b     <= '0;
                    o_byte_c     <= '0;
                    o_byte_count <= sspd_pkg::CNT_ONE;
                    o_strobe_end <= 1'b1;
                end
                sspd_pkg::STEP_ADDR: begin
                    o_kind       <= sspd_pkg::KIND_ADDR;
                    o_byte_a     <= sspd_pkg::CMD_ADDR;
                    o_byte_b     <= '0;
                    o_byte_c     <= '0;
                    o_byte_count <= sspd_pkg::CNT_ONE;
                    o_strobe_end <= 1'b0;
                end
                sspd_pkg::STEP_CTRL: begin
                    o_kind       <= sspd_pkg::KIND_CTRL;
                    o_byte_a     <= sspd_pkg::CMD_CTRL;
                    o_byte_b     <= '0;
                    o_byte_c     <= '0;
                    o_byte_count <= sspd_pkg::CNT_ONE;
                    o_strobe_end <= 1'b1;
                    o_last       <= (i_cmd.chip == sspd_pkg::CHIP_W'(sspd_pkg::CHIPS - 1));
                end
                default: begin
                    o_kind       <= sspd_pkg::KIND_DATA;
                    o_byte_a     <= rd_codes[23:16];
                    o_byte_b     <= rd_codes[15:8];
                    o_byte_c     <= rd_codes[7:0];
                    o_byte_count <= sspd_pkg::CNT_THREE;
                    // chip select released after the chip's last group
                    o_strobe_end <= (grp == sspd_pkg::STEP_W'(sspd_pkg::PORTS_PER_CHIP - 1));
                end
            endcase
        end
    end

endmodule

// File: src/seven_segment_port_display_driver.sv
// Seven-segment port display driver, top level: joins controller and datapath.
// Depends on sspd_pkg, sspd_in_if, sspd_out_if, sspd_ctrl, sspd_dpath.
//
// The block keeps one three-digit display code for each of 20 ports and, on
// every input transfer that names a port from 1 to 20, stores the new value
// and replays a full refresh of all four driver chips: per chip a mode
// command, an address command, five segment-data groups and a display
// control byte, 32 output transfers in all. Ports 0 and above 20 are taken
// and dropped with no output. A value of 0xFFFF shows dashes; any other value
// shows its low three decimal digits. The value is turned into BCD when it
// arrives (double dabble, four bits per cycle) and kept as segment
// codes, so the refresh only reads the code store. Each item passes through
// an accept, the conversion steps, a store write and the output transfers,
// which go out one per cycle unless the sink stalls. Input ready is high
// only between refreshes; the final transfer may still sit in the output
// register when the next item is taken.
module seven_segment_port_display_driver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sspd_in_if.sink    i_in,
    sspd_out_if.source o_out
);

    sspd_pkg::t_cmd    cmd;
    sspd_pkg::t_status status;

    // sequencing: idle -> convert -> store -> refresh transfers
    sspd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // conversion, code store and output payload register
    sspd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_port       (i_in.port),
        .i_value      (i_in.value),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_chip       (o_out.chip),
        .o_kind       (o_out.kind),
        .o_byte_a     (o_out.byte_a),
        .o_byte_b     (o_out.byte_b),
        .o_byte_c     (o_out.byte_c),
        .o_byte_count (o_out.byte_count),
        .o_strobe_end (o_out.strobe_end),
        .o_last       (o_out.last)
    );

endmodule

// File: src/sspd_chk.sv
// Port-level checker for the display driver, bound to the top level.
// Depends on sspd_pkg and seven_segment_port_display_driver.
module sspd_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [sspd_pkg::CHIPSEL_W-1:0]   i_chip,
    input logic [1:0]                       i_kind,
    input logic [sspd_pkg::SEG_W-1:0]       i_byte_a,
    input logic [1:0]                       i_byte_count,
    input logic                             i_strobe_end,
    input logic                             i_last
);

    // stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_chip) && $stable(i_kind)
            && $stable(i_byte_a))
        else $error("output transfer changed while stalled");

    // no new item while a refresh is still underway
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input taken in the middle of a refresh");

    // mode command is followed by address command on the same chip
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_kind == sspd_pkg::KIND_MODE
            |=> i_out_valid && i_kind == sspd_pkg::KIND_ADDR && $stable(i_chip))
        else $error("address command does not follow mode command");

    // end of refresh only on the last chip's control byte
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> i_kind == sspd_pkg::KIND_CTRL && i_strobe_end
            && i_chip == sspd_pkg::CHIPSEL_W'(sspd_pkg::CHIPS))
        else $error("last flag on wrong transfer");

    // byte count agrees with the transfer kind
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == sspd_pkg::KIND_DATA) == (i_byte_count == sspd_pkg::CNT_THREE))
        else $error("byte count does not match transfer kind");

endmodule

bind seven_segment_port_display_driver sspd_chk u_sspd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_chip       (o_out.chip),
    .i_kind       (o_out.kind),
    .i_byte_a     (o_out.byte_a),
    .i_byte_count (o_out.byte_count),
    .i_strobe_end (o_out.strobe_end),
    .i_last       (o_out.last)
);
